// ----- src/modulo_reservation_table_macros.svh -----
// assertion macros for the modulo reservation table
// used by modules that check their own control logic, needs i_clk and i_rst_n in scope
`ifndef MODULO_RESERVATION_TABLE_MACROS_SVH
`define MODULO_RESERVATION_TABLE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrt assertion failed");

// antecedent implies consequent in the following cycle
`define MRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrt assertion failed");

`endif

// ----- src/mrt_pkg.sv -----
// shared types and codes for the modulo reservation table
// no dependencies
package mrt_pkg;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] resource_id;
        logic [6:0] time_slot;
        logic [4:0] span_length;
        logic [1:0] occupancy_kind;
        logic [7:0] op_id;
    } t_in;

    typedef struct packed {
        logic       ok;
        logic [2:0] kind_found;
        logic [1:0] error_code;
    } t_out;

    localparam logic [2:0] CMD_BIND_CELL  = 3'd0;
    localparam logic [2:0] CMD_BIND_SPAN  = 3'd1;
    localparam logic [2:0] CMD_RELEASE    = 3'd2;
    localparam logic [2:0] CMD_QUERY_FREE = 3'd3;
    localparam logic [2:0] CMD_QUERY_KIND = 3'd4;

    localparam logic [1:0] KIND_SINGLE  = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_IN_PIPE = 2'd3;
    localparam logic [2:0] KIND_NONE    = 3'd4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic CFG_II      = 1'b0;
    localparam logic CFG_SPATIAL = 1'b1;

    // entry layout: valid, kind, op id
    localparam int ENTRY_W = 11;
    localparam int E_VALID = 10;

    typedef struct packed {
        logic accept;
        logic mod_step;
        logic scan_start;
        logic scan_rd;
        logic scan_ev;
        logic step_next;
        logic scan_end;
        logic wr_start;
        logic wr_rd;
        logic wr_ev;
        logic rel_rd;
        logic rel_ev;
        logic clr_wr;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic early_done;
        logic is_release;
        logic mod_done;
        logic scan_last;
        logic step_last;
        logic is_bind;
        logic bind_ok;
        logic sweep_last;
        logic out_busy;
    } t_dp_st;

    function automatic logic [1:0] span_kind(input logic [4:0] i, input logic [4:0] len);
        logic [1:0] k;
        if (i == 5'd0) begin
            k = KIND_START;
        end else if (i == len - 5'd1) begin
            k = KIND_END;
        end else begin
            k = KIND_IN_PIPE;
        end
        return k;
    endfunction

endpackage

// ----- src/mrt_ctrl.sv -----
// controller state machine of the modulo reservation table
// depends on mrt_pkg and modulo_reservation_table_macros.svh
`include "modulo_reservation_table_macros.svh"

module mrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mrt_pkg::t_dp_st i_st,
    output mrt_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MOD     = 4'd2;
    localparam logic [3:0] S_SCAN_RD = 4'd3;
    localparam logic [3:0] S_SCAN_EV = 4'd4;
    localparam logic [3:0] S_CHECK   = 4'd5;
    localparam logic [3:0] S_WR_RD   = 4'd6;
    localparam logic [3:0] S_WR_EV   = 4'd7;
    localparam logic [3:0] S_REL_RD  = 4'd8;
    localparam logic [3:0] S_REL_EV  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_st.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.is_release) n_state = S_REL_RD;
                    else if (i_st.early_done) n_state = S_DONE;
                    else n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_st.mod_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                if (!i_st.scan_last) begin
                    n_state = S_SCAN_RD;
                end else if (i_st.step_last) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.step_next = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_CHECK: begin
                o_cmd.scan_end = 1'b1;
                if (i_st.is_bind && i_st.bind_ok) begin
                    o_cmd.wr_start = 1'b1;
                    n_state = S_WR_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WR_RD: begin
                o_cmd.wr_rd = 1'b1;
                n_state = S_WR_EV;
            end
            S_WR_EV: begin
                o_cmd.wr_ev = 1'b1;
                if (i_st.step_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step_next = 1'b1;
                    n_state = S_WR_RD;
                end
            end
            S_REL_RD: begin
                o_cmd.rel_rd = 1'b1;
                n_state = S_REL_EV;
            end
            S_REL_EV: begin
                o_cmd.rel_ev = 1'b1;
                n_state = i_st.sweep_last ? S_DONE : S_REL_RD;
            end
            S_DONE: begin
                if (!i_st.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // no transfer is taken while the table is being cleared
    `MRT_ASSERT_NOW(a_no_accept_in_clear, r_state == S_CLEAR, !o_ready)
    // an accepted item always leaves idle
    `MRT_ASSERT_NEXT(a_accept_leaves_idle, i_valid && o_ready, r_state != S_IDLE)
    // a finished result with a free output slot returns to idle
    `MRT_ASSERT_NEXT(a_done_to_idle, r_state == S_DONE && !i_st.out_busy, r_state == S_IDLE)
    // a failed check goes straight to done, without writing to the table
    `MRT_ASSERT_NEXT(a_write_after_check, r_state == S_CHECK && !(i_st.is_bind && i_st.bind_ok),
        r_state == S_DONE)

endmodule

// ----- src/mrt_dp.sv -----
// datapath of the modulo reservation table: table memory, scan counters, result register
// depends on mrt_pkg, driven by mrt_ctrl
module mrt_dp #(
    parameter int RESOURCES        = 16,
    parameter int MAX_STEPS        = 8,
    parameter int ENTRIES_PER_CELL = 4,
    parameter int MAX_II           = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [4:0]        i_cfg_data,
    input  mrt_pkg::t_in      i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output mrt_pkg::t_out     o_data,
    input  mrt_pkg::t_dp_cmd  i_cmd,
    output mrt_pkg::t_dp_st   o_st
);

    localparam int SPR    = MAX_II * MAX_STEPS;
    localparam int DEPTH  = RESOURCES * SPR;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW     = mrt_pkg::ENTRY_W;
    localparam int ROW_W  = ENTRIES_PER_CELL * EW;
    localparam int LIM_W  = $clog2(SPR + 1);
    localparam int TW     = ((LIM_W > 8) ? LIM_W : 8) + 1;

    // configuration
    logic [4:0] r_ii;
    logic       r_spatial;

    // item fields
    logic [2:0] r_cmd;
    logic [3:0] r_res;
    logic [6:0] r_time;
    logic [4:0] r_len;
    logic [1:0] r_kind;
    logic [7:0] r_op;

    logic [TW-1:0] r_rem;
    logic [TW-1:0] r_t;
    logic [TW-1:0] r_tgt;
    logic [4:0]    r_i;
    logic [AW-1:0] r_addr;
    logic          r_good;
    logic          r_room;
    logic          r_free;
    logic          r_ok;
    logic [2:0]    r_found;
    logic [1:0]    r_err;

    logic          r_ovalid;
    mrt_pkg::t_out r_odata;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] r_rd;

    logic [TW-1:0] p;
    logic [TW-1:0] lim;
    logic [TW-1:0] st;
    logic [TW-1:0] t_next;
    logic [TW-1:0] rem_inc;
    logic [1:0]    kind_i;
    logic [1:0]    err_in;
    logic          is_bind;
    logic [AW-1:0] base;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;
    logic          wr_en;
    logic          rd_en;

    function automatic logic row_compat(input logic [ROW_W-1:0] row, input logic [1:0] k);
        logic       res;
        logic [1:0] ex;
        res = 1'b1;
        for (int e = 0; e < ENTRIES_PER_CELL; e++) begin
            ex = row[e*EW+8 +: 2];
            if (row[e*EW+mrt_pkg::E_VALID]) begin
                if (ex == mrt_pkg::KIND_SINGLE || k == mrt_pkg::KIND_SINGLE) res = 1'b0;
                if (k == mrt_pkg::KIND_START && ex == mrt_pkg::KIND_START) res = 1'b0;
                if (k == mrt_pkg::KIND_END && ex == mrt_pkg::KIND_END) res = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic row_room(input logic [ROW_W-1:0] row);
        logic res;
        res = 1'b0;
        for (int e = 0; e < ENTRIES_PER_CELL; e++) begin
            if (!row[e*EW+mrt_pkg::E_VALID]) res = 1'b1;
        end
        return res;
    endfunction

    function automatic logic row_in_pipe_only(input logic [ROW_W-1:0] row);
        logic res;
        res = 1'b1;
        for (int e = 0; e < ENTRIES_PER_CELL; e++) begin
            if (row[e*EW+mrt_pkg::E_VALID] && row[e*EW+8 +: 2] != mrt_pkg::KIND_IN_PIPE) begin
                res = 1'b0;
            end
        end
        return res;
    endfunction

    // kind of the first valid entry, or none
    function automatic logic [2:0] row_first_kind(input logic [ROW_W-1:0] row);
        logic [2:0] res;
        res = mrt_pkg::KIND_NONE;
        for (int e = ENTRIES_PER_CELL - 1; e >= 0; e--) begin
            if (row[e*EW+mrt_pkg::E_VALID]) res = {1'b0, row[e*EW+8 +: 2]};
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] row_add(input logic [ROW_W-1:0] row,
                                                 input logic [1:0] k, input logic [7:0] op);
        logic [ROW_W-1:0] res;
        logic             done;
        res  = row;
        done = 1'b0;
        for (int e = 0; e < ENTRIES_PER_CELL; e++) begin
            if (!done && !row[e*EW+mrt_pkg::E_VALID]) begin
                res[e*EW +: EW] = {1'b1, k, op};
                done = 1'b1;
            end
        end
        return res;
    endfunction

    // drop entries of op, keep the rest in order
    function automatic logic [ROW_W-1:0] row_compact(input logic [ROW_W-1:0] row,
                                                     input logic [7:0] op);
        logic [ROW_W-1:0] res;
        int               n;
        res = '0;
        n   = 0;
        for (int e = 0; e < ENTRIES_PER_CELL; e++) begin
            if (row[e*EW+mrt_pkg::E_VALID] && row[e*EW +: 8] != op) begin
                res[n*EW +: EW] = row[e*EW +: EW];
                n = n + 1;
            end
        end
        return res;
    endfunction

    always_comb begin
        if (r_ii == 5'd0) begin
            p = TW'(1);
        end else if (TW'(r_ii) > TW'(MAX_II)) begin
            p = TW'(MAX_II);
        end else begin
            p = TW'(r_ii);
        end
    end

    assign lim     = p * TW'(MAX_STEPS);
    assign st      = r_spatial ? TW'(1) : p;
    assign t_next  = r_t + st;
    assign rem_inc = (r_rem + TW'(1) == p) ? '0 : r_rem + TW'(1);
    assign is_bind = (r_cmd == mrt_pkg::CMD_BIND_CELL) || (r_cmd == mrt_pkg::CMD_BIND_SPAN);
    assign kind_i  = (r_cmd == mrt_pkg::CMD_BIND_CELL) ? r_kind : mrt_pkg::span_kind(r_i, r_len);

    // early outcome of an incoming item
    always_comb begin
        err_in = mrt_pkg::ERR_NONE;
        if (i_data.command <= mrt_pkg::CMD_QUERY_KIND
            && i_data.command != mrt_pkg::CMD_RELEASE) begin
            if (9'(i_data.resource_id) >= 9'(RESOURCES) || TW'(i_data.time_slot) >= lim) begin
                err_in = mrt_pkg::ERR_RANGE;
            end else if (i_data.command == mrt_pkg::CMD_BIND_SPAN
                         && (i_data.span_length == 5'd0
                             || TW'(i_data.time_slot) + TW'(i_data.span_length) > lim)) begin
                err_in = mrt_pkg::ERR_RANGE;
            end
        end
    end

    assign o_st.is_release = (i_data.command == mrt_pkg::CMD_RELEASE);
    assign o_st.early_done = (i_data.command > mrt_pkg::CMD_QUERY_KIND)
                             || (err_in != mrt_pkg::ERR_NONE);
    assign o_st.mod_done   = (r_rem < p);
    assign o_st.scan_last  = (t_next >= lim);
    assign o_st.step_last  = (r_cmd != mrt_pkg::CMD_BIND_SPAN) || (6'(r_i) + 6'd1 == 6'(r_len));
    assign o_st.is_bind    = is_bind;
    assign o_st.bind_ok    = r_good && r_room;
    assign o_st.sweep_last = (r_addr == AW'(DEPTH - 1));
    assign o_st.out_busy   = r_ovalid && !i_ready;

    // memory addressing
    assign base = AW'(r_res) * AW'(SPR);
    always_comb begin
        priority if (i_cmd.scan_rd) begin
            rd_addr = base + AW'(r_t);
        end else if (i_cmd.wr_rd) begin
            rd_addr = base + AW'(r_tgt);
        end else begin
            rd_addr = r_addr;
        end
    end
    assign rd_en = i_cmd.scan_rd || i_cmd.wr_rd || i_cmd.rel_rd;

    always_comb begin
        wr_en   = i_cmd.clr_wr || i_cmd.rel_ev || i_cmd.wr_ev;
        wr_addr = r_addr;
        wr_data = '0;
        priority if (i_cmd.wr_ev) begin
            wr_addr = base + AW'(r_tgt);
            wr_data = row_add(r_rd, kind_i, r_op);
        end else if (i_cmd.rel_ev) begin
            wr_data = row_compact(r_rd, r_op);
        end else begin
            wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ii      <= 5'd1;
            r_spatial <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mrt_pkg::CFG_II:      r_ii      <= i_cfg_data;
                mrt_pkg::CFG_SPATIAL: r_spatial <= i_cfg_data[0];
                default:              r_ii      <= r_ii;
            endcase
        end
    end

    // sweep address, also used for the clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.accept) begin
            r_addr <= '0;
        end else if (i_cmd.clr_wr || i_cmd.rel_ev) begin
            r_addr <= o_st.sweep_last ? '0 : r_addr + AW'(1);
        end
    end

    // item and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_data.command;
            r_res   <= i_data.resource_id;
            r_time  <= i_data.time_slot;
            r_len   <= i_data.span_length;
            r_kind  <= i_data.occupancy_kind;
            r_op    <= i_data.op_id;
            r_rem   <= TW'(i_data.time_slot);
            r_tgt   <= TW'(i_data.time_slot);
            r_i     <= 5'd0;
            r_good  <= 1'b1;
            r_room  <= 1'b1;
            r_free  <= 1'b1;
            r_ok    <= 1'b0;
            r_found <= mrt_pkg::KIND_NONE;
            r_err   <= err_in;
        end
        if (i_cmd.mod_step) r_rem <= r_rem - p;
        if (i_cmd.scan_start) r_t <= r_spatial ? '0 : r_rem;
        if (i_cmd.scan_ev) begin
            // the next span step restarts the scan below
            if (!i_cmd.step_next) r_t <= t_next;
            if (is_bind) begin
                if (!row_compat(r_rd, kind_i)) r_good <= 1'b0;
                if (r_t == r_tgt && !row_room(r_rd)) r_room <= 1'b0;
            end
            if (r_cmd == mrt_pkg::CMD_QUERY_FREE && !row_in_pipe_only(r_rd)) r_free <= 1'b0;
            if (r_cmd == mrt_pkg::CMD_QUERY_KIND && r_found == mrt_pkg::KIND_NONE) begin
                r_found <= row_first_kind(r_rd);
            end
        end
        if (i_cmd.step_next) begin
            r_i   <= r_i + 5'd1;
            r_tgt <= r_tgt + TW'(1);
            r_rem <= rem_inc;
            r_t   <= r_spatial ? '0 : rem_inc;
        end
        if (i_cmd.scan_end) begin
            if (r_cmd == mrt_pkg::CMD_QUERY_FREE) r_ok <= r_free;
            if (is_bind && r_good && !r_room) r_err <= mrt_pkg::ERR_FULL;
        end
        if (i_cmd.wr_start) begin
            r_i   <= 5'd0;
            r_tgt <= TW'(r_time);
        end
        if (i_cmd.wr_ev && o_st.step_last) r_ok <= 1'b1;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata.ok         <= r_ok;
            r_odata.kind_found <= r_found;
            r_odata.error_code <= r_err;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

// ----- src/modulo_reservation_table.sv -----
// Modulo reservation table, top level.
// Input channel i_valid/o_ready carries one command (mrt_pkg::t_in) per transfer;
// output channel o_valid/i_ready returns one result (mrt_pkg::t_out) per command.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 ii, 1 spatial_only);
// the user must write only while no command is in flight; the block does not enforce it.
// One command at a time. A bind or query first reduces time_slot modulo ii by
// repeated subtraction, then reads and checks one table row per scanned cell:
// MAX_STEPS cells, or all ii*MAX_STEPS in spatial mode, for each step of a span;
// a successful bind then reads and rewrites each cell it writes. Release reads
// every row and writes it back without the op's entries.
// After reset the table is cleared one row a cycle, all RESOURCES*MAX_II*MAX_STEPS
// rows, with o_ready low; configuration writes are taken meanwhile.
// A result waits in the output register while i_ready is low; the next command is
// accepted meanwhile and finishes into that register once it drains.
module modulo_reservation_table #(
    parameter int RESOURCES        = 16,
    parameter int MAX_STEPS        = 8,
    parameter int ENTRIES_PER_CELL = 4,
    parameter int MAX_II           = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [4:0]    i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  mrt_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output mrt_pkg::t_out o_data
);

    mrt_pkg::t_dp_cmd dp_cmd;
    mrt_pkg::t_dp_st  dp_st;

    mrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_st    (dp_st),
        .o_cmd   (dp_cmd)
    );

    mrt_dp #(
        .RESOURCES        (RESOURCES),
        .MAX_STEPS        (MAX_STEPS),
        .ENTRIES_PER_CELL (ENTRIES_PER_CELL),
        .MAX_II           (MAX_II)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cmd      (dp_cmd),
        .o_st       (dp_st)
    );

endmodule

// ----- bench/modulo_reservation_table_tb.sv -----
// testbench for modulo_reservation_table: directed and random commands, scoreboard
// against a behavioural table model; depends on mrt_pkg and the block itself
`timescale 1ns / 1ps

module modulo_reservation_table_tb;

    localparam int RES   = 16;
    localparam int STEPS = 8;
    localparam int EPC   = 4;
    localparam int MII   = 16;
    localparam int SPR   = MII * STEPS;
    localparam int WD_LIMIT = 50000;

    typedef struct packed {
        logic       vld;
        logic [1:0] kind;
        logic [7:0] op;
    } t_entry;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [4:0] i_cfg_data;
    logic i_valid;
    logic o_ready;
    mrt_pkg::t_in  i_data;
    logic o_valid;
    logic i_ready;
    mrt_pkg::t_out o_data;

    modulo_reservation_table DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    // model state
    t_entry     tbl [RES][SPR][EPC];
    logic [4:0] m_ii;
    logic       m_spatial;

    mrt_pkg::t_out expected_q[$];
    int   fail_cnt;
    int   idle_cnt;
    bit   hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_ii();
        if (m_ii < 1) return 1;
        if (m_ii > MII) return MII;
        return int'(m_ii);
    endfunction

    function automatic bit cell_fits(int r, int t, logic [1:0] k);
        for (int e = 0; e < EPC; e++) begin
            if (!tbl[r][t][e].vld) continue;
            if (tbl[r][t][e].kind == mrt_pkg::KIND_SINGLE || k == mrt_pkg::KIND_SINGLE) return 0;
            if (k == mrt_pkg::KIND_START && tbl[r][t][e].kind == mrt_pkg::KIND_START) return 0;
            if (k == mrt_pkg::KIND_END && tbl[r][t][e].kind == mrt_pkg::KIND_END) return 0;
        end
        return 1;
    endfunction

    function automatic bit cell_room(int r, int t);
        for (int e = 0; e < EPC; e++)
            if (!tbl[r][t][e].vld) return 1;
        return 0;
    endfunction

    function automatic void cell_put(int r, int t, logic [1:0] k, logic [7:0] op);
        for (int e = 0; e < EPC; e++) begin
            if (!tbl[r][t][e].vld) begin
                tbl[r][t][e] = '{1'b1, k, op};
                return;
            end
        end
    endfunction

    function automatic bit slots_fit(int r, int tm, logic [1:0] k);
        int p, lim, t0, st;
        p = eff_ii();
        lim = p * STEPS;
        t0 = m_spatial ? 0 : tm % p;
        st = m_spatial ? 1 : p;
        for (int t = t0; t < lim; t += st)
            if (!cell_fits(r, t, k)) return 0;
        return 1;
    endfunction

    function automatic logic [1:0] step_kind(int i, int len);
        if (i == 0) return mrt_pkg::KIND_START;
        if (i == len - 1) return mrt_pkg::KIND_END;
        return mrt_pkg::KIND_IN_PIPE;
    endfunction

    // applies one command to the table and returns the result it should give
    function automatic mrt_pkg::t_out table_apply(mrt_pkg::t_in c);
        mrt_pkg::t_out res;
        int r, tm, len, lim, p, t0, st;
        bit good, room, free_ok;
        t_entry keep [EPC];
        int n;
        res = '{1'b0, mrt_pkg::KIND_NONE, mrt_pkg::ERR_NONE};
        r = c.resource_id;
        tm = c.time_slot;
        len = c.span_length;
        p = eff_ii();
        lim = p * STEPS;
        if (c.command == mrt_pkg::CMD_RELEASE) begin
            for (int a = 0; a < RES; a++)
                for (int b = 0; b < SPR; b++) begin
                    n = 0;
                    for (int e = 0; e < EPC; e++)
                        if (tbl[a][b][e].vld && tbl[a][b][e].op != c.op_id) begin
                            keep[n] = tbl[a][b][e];
                            n++;
                        end
                    for (int e = 0; e < EPC; e++)
                        tbl[a][b][e] = (e < n) ? keep[e] : '0;
                end
        end else if (c.command <= mrt_pkg::CMD_QUERY_KIND) begin
            if (r >= RES || tm >= lim) begin
                res.error_code = mrt_pkg::ERR_RANGE;
            end else if (c.command == mrt_pkg::CMD_BIND_CELL) begin
                if (slots_fit(r, tm, c.occupancy_kind)) begin
                    if (cell_room(r, tm)) begin
                        cell_put(r, tm, c.occupancy_kind, c.op_id);
                        res.ok = 1'b1;
                    end else begin
                        res.error_code = mrt_pkg::ERR_FULL;
                    end
                end
            end else if (c.command == mrt_pkg::CMD_BIND_SPAN) begin
                if (len == 0 || tm + len > lim) begin
                    res.error_code = mrt_pkg::ERR_RANGE;
                end else begin
                    good = 1;
                    room = 1;
                    for (int i = 0; i < len && good; i++)
                        good = slots_fit(r, tm + i, step_kind(i, len));
                    for (int i = 0; i < len && good && room; i++)
                        room = cell_room(r, tm + i);
                    if (good && !room) res.error_code = mrt_pkg::ERR_FULL;
                    if (good && room) begin
                        for (int i = 0; i < len; i++)
                            cell_put(r, tm + i, step_kind(i, len), c.op_id);
                        res.ok = 1'b1;
                    end
                end
            end else begin
                t0 = m_spatial ? 0 : tm % p;
                st = m_spatial ? 1 : p;
                free_ok = 1;
                for (int t = t0; t < lim; t += st) begin
                    for (int e = 0; e < EPC; e++) begin
                        if (!tbl[r][t][e].vld) continue;
                        if (c.command == mrt_pkg::CMD_QUERY_FREE) begin
                            if (tbl[r][t][e].kind != mrt_pkg::KIND_IN_PIPE) free_ok = 0;
                        end else if (res.kind_found == mrt_pkg::KIND_NONE) begin
                            res.kind_found = {1'b0, tbl[r][t][e].kind};
                        end
                    end
                    if (c.command == mrt_pkg::CMD_QUERY_FREE && !free_ok) break;
                    if (c.command == mrt_pkg::CMD_QUERY_KIND
                        && res.kind_found != mrt_pkg::KIND_NONE) break;
                end
                if (c.command == mrt_pkg::CMD_QUERY_FREE) res.ok = free_ok;
            end
        end
        return res;
    endfunction

    // sender, valid stays up after a transfer until the next item or a drain
    task automatic send_cmd(mrt_pkg::t_in c, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.insert(expected_q.size(), table_apply(c));
    endtask

    function automatic mrt_pkg::t_in mk(logic [2:0] cmd, int r, int t, int len, logic [1:0] k,
                                        int op);
        mrt_pkg::t_in c;
        c.command = cmd;
        c.resource_id = r[3:0];
        c.time_slot = t[6:0];
        c.span_length = len[4:0];
        c.occupancy_kind = k;
        c.op_id = op[7:0];
        return c;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [4:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mrt_pkg::CFG_II) m_ii = val;
        else m_spatial = val[0];
        @(posedge i_clk);
    endtask

    task automatic release_all();
        for (int op = 0; op < 8; op++)
            send_cmd(mk(mrt_pkg::CMD_RELEASE, 0, 0, 1, mrt_pkg::KIND_SINGLE, op));
    endtask

    // random command with content biased to a small op pool and in-range cells
    function automatic mrt_pkg::t_in rand_cmd();
        mrt_pkg::t_in c;
        logic [31:0] raw;
        int lim, sel;
        lim = eff_ii() * STEPS;
        raw = $urandom;
        c = raw[$bits(mrt_pkg::t_in)-1:0];
        sel = $urandom_range(0, 99);
        if (sel < 30) c.command = mrt_pkg::CMD_BIND_CELL;
        else if (sel < 55) c.command = mrt_pkg::CMD_BIND_SPAN;
        else if (sel < 60) c.command = mrt_pkg::CMD_RELEASE;
        else if (sel < 75) c.command = mrt_pkg::CMD_QUERY_FREE;
        else if (sel < 92) c.command = mrt_pkg::CMD_QUERY_KIND;
        else c.command = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) != 0) begin
            c.resource_id = 4'($urandom_range(0, 3));
            c.time_slot = 7'($urandom_range(0, lim - 1));
            c.span_length = 5'($urandom_range(1, 4));
            c.op_id = 8'($urandom_range(0, 7));
        end
        return c;
    endfunction

    task automatic test_directed();
        send_cmd(mk(mrt_pkg::CMD_QUERY_KIND, 0, 0, 1, mrt_pkg::KIND_SINGLE, 0));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 0, 0, 1, mrt_pkg::KIND_SINGLE, 1));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 0, 0, 1, mrt_pkg::KIND_START, 2));
        send_cmd(mk(mrt_pkg::CMD_QUERY_KIND, 0, 0, 1, mrt_pkg::KIND_SINGLE, 0));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 15, 7, 1, mrt_pkg::KIND_IN_PIPE, 255));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 15, 7, 1, mrt_pkg::KIND_IN_PIPE, 254));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 15, 7, 1, mrt_pkg::KIND_START, 3));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 15, 7, 1, mrt_pkg::KIND_END, 4));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 15, 7, 1, mrt_pkg::KIND_IN_PIPE, 5));
        send_cmd(mk(mrt_pkg::CMD_QUERY_FREE, 15, 7, 1, mrt_pkg::KIND_SINGLE, 0));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 0, 8, 1, mrt_pkg::KIND_SINGLE, 6));
        send_cmd(mk(mrt_pkg::CMD_BIND_CELL, 0, 127, 1, mrt_pkg::KIND_SINGLE, 6));
        send_cmd(mk(mrt_pkg::CMD_BIND_SPAN, 3, 0, 0, mrt_pkg::KIND_SINGLE, 7));
        send_cmd(mk(mrt_pkg::CMD_BIND_SPAN, 3, 5, 4, mrt_pkg::KIND_SINGLE, 7));
        send_cmd(mk(mrt_pkg::CMD_BIND_SPAN, 3, 2, 3, mrt_pkg::KIND_SINGLE, 7));
        send_cmd(mk(mrt_pkg::CMD_BIND_SPAN, 3, 0, 1, mrt_pkg::KIND_SINGLE, 8));
        send_cmd(mk(mrt_pkg::CMD_QUERY_FREE, 3, 3, 1, mrt_pkg::KIND_SINGLE, 0));
        send_cmd(mk(mrt_pkg::CMD_QUERY_KIND, 3, 3, 1, mrt_pkg::KIND_SINGLE, 0));
        send_cmd(mk(mrt_pkg::CMD_BIND_SPAN, 2, 0, 31, mrt_pkg::KIND_SINGLE, 9));
        send_cmd(mk(mrt_pkg::CMD_RELEASE, 0, 0, 1, mrt_pkg::KIND_SINGLE, 255));
        send_cmd(mk(mrt_pkg::CMD_QUERY_FREE, 15, 7, 1, mrt_pkg::KIND_SINGLE, 0));
        send_cmd(mk(3'd5, 0, 0, 1, mrt_pkg::KIND_SINGLE, 0));
        send_cmd(mk(3'd7, 15, 127, 31, mrt_pkg::KIND_IN_PIPE, 255));
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_cmd(rand_cmd());
        drain();
    endtask

    task automatic test_stall_fill();
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++) send_cmd(rand_cmd(), 1);
        hold_off = 1'b0;
        drain();
    endtask

    task automatic test_config_sweep();
        logic [4:0] ii_vals [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd7};
        foreach (ii_vals[j]) begin
            write_cfg(mrt_pkg::CFG_II, ii_vals[j]);
            write_cfg(mrt_pkg::CFG_SPATIAL, 5'($urandom_range(0, 1)));
            release_all();
            drain();
            test_random(200);
        end
        write_cfg(mrt_pkg::CFG_SPATIAL, 5'd1);
        write_cfg(mrt_pkg::CFG_II, 5'd2);
        test_random(150);
        write_cfg(mrt_pkg::CFG_SPATIAL, 5'd0);
    endtask

    // receiver: random stall per result, plus the long hold-off
    initial begin
        int wait_n;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            wait_n = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 12);
            if (wait_n != 0) begin
                i_ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_valid && i_ready)) @(posedge i_clk);
            i_ready <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        mrt_pkg::t_out exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, o_data);
                fail_cnt++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_data.ok !== exp_r.ok) begin
                    $display("%0t: ok exp %0d got %0d", $realtime, exp_r.ok, o_data.ok);
                    fail_cnt++;
                end
                if (o_data.kind_found !== exp_r.kind_found) begin
                    $display("%0t: kind_found exp %0d got %0d", $realtime,
                             exp_r.kind_found, o_data.kind_found);
                    fail_cnt++;
                end
                if (o_data.error_code !== exp_r.error_code) begin
                    $display("%0t: error_code exp %0d got %0d", $realtime,
                             exp_r.error_code, o_data.error_code);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT) begin
            $display("modulo_reservation_table_tb NOT OK");
            $finish;
        end
    end

    initial begin
        fail_cnt = 0;
        hold_off = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= mrt_pkg::CFG_II;
        i_cfg_data <= '0;
        m_ii = 5'd1;
        m_spatial = 1'b0;
        foreach (tbl[a, b, e]) tbl[a][b][e] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_stall_fill();
        test_random(200);
        test_config_sweep();
        drain();
        repeat (4200) @(posedge i_clk);
        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("modulo_reservation_table_tb OK");
        end else begin
            $display("modulo_reservation_table_tb NOT OK");
        end
        $finish;
    end

endmodule
